// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/frac_pkg.sv -----
package frac_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int FIELD_W       = 32;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int MAG_W         = 2 * OPERAND_WIDTH - 1;
   localparam int CNT_W         = $clog2(MAG_W);
   localparam int NUM_OUT_W     = 64;
   localparam int DEN_OUT_W     = 62;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [FIELD_W-1:0] left_num;
      logic signed [FIELD_W-1:0] left_den;
      logic signed [FIELD_W-1:0] right_num;
      logic signed [FIELD_W-1:0] right_den;
   } frac_req_type;

   typedef struct packed {
      logic signed [NUM_OUT_W-1:0] result_num;
      logic [DEN_OUT_W-1:0]        result_den;
      logic                        status;
   } frac_rsp_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_idx;
      logic       sum_en;
      logic       gcd_init;
      logic       gcd_step;
      logic       gcd_fin;
      logic       div_step;
      logic       out_load;
   } frac_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic gcd_done;
   } frac_stat_type;

endpackage

// ----- hw/rtl/frac_ctrl.sv -----
module frac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  frac_pkg::frac_stat_type stat,
   output frac_pkg::frac_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_SUM  = 7'b0000100,
      ST_INIT = 7'b0001000,
      ST_GCD  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [frac_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        valid_ff, valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_idx = cnt_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (cnt_ff == frac_pkg::CNT_W'(2)) begin
               cnt_in   = '0;
               state_in = ST_SUM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = stat.den_zero ? ST_FIN : ST_GCD;
         end
         ST_GCD: begin
            if (stat.gcd_done) begin
               cmd.gcd_fin = 1'b1;
               cnt_in      = '0;
               state_in    = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == frac_pkg::CNT_W'(frac_pkg::MAG_W - 1)) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- hw/rtl/frac_dp.sv -----
module frac_dp (
   input  logic                    clock,
   input  frac_pkg::frac_req_type  req_data,
   input  frac_pkg::frac_cmd_type  cmd,
   output frac_pkg::frac_stat_type stat,
   output frac_pkg::frac_rsp_type  rsp_data
);

   localparam int W = frac_pkg::OPERAND_WIDTH;
   localparam int P = frac_pkg::PROD_W;
   localparam int M = frac_pkg::MAG_W;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] take_op(input logic [frac_pkg::FIELD_W-1:0] raw);
      logic [W-1:0] v;
      v = raw[W-1:0];
      return (v == MOST_NEG) ? (MOST_NEG + W'(1)) : v;
   endfunction

   logic [1:0]              op_ff;
   logic signed [W-1:0]     ln_ff, ld_ff, rn_ff, rd_ff;
   logic signed [P-1:0]     p0_ff, p1_ff, p2_ff;
   logic signed [P-1:0]     num_ff, den_ff;
   logic signed [W-1:0]     ma, mb;
   logic signed [P-1:0]     prod;
   logic signed [P-1:0]     num_in;
   logic [P-1:0]            nabs, dabs;
   logic                    neg_ff, zero_ff;
   logic [M-1:0]            a_ff, b_ff, g_ff;
   logic [frac_pkg::CNT_W-1:0] k_ff;
   logic [M-1:0]            a_in, b_in;
   logic [frac_pkg::CNT_W-1:0] k_in;
   logic [M-1:0]            qn_ff, qd_ff, rn_rem_ff, rd_rem_ff;
   logic [M:0]              tn, td, tn_sub, td_sub, g_ext;
   logic                    gen, ged;
   logic [frac_pkg::NUM_OUT_W-1:0] qn_ext;

   // Shared multiplier: one product per cycle.
   always_comb begin
      case (cmd.mul_idx)
         2'd0: begin
            ma = ln_ff;
            mb = (op_ff == frac_pkg::OP_MUL) ? rn_ff : rd_ff;
         end
         2'd1: begin
            ma = ld_ff;
            mb = rn_ff;
         end
         default: begin
            ma = ld_ff;
            mb = (op_ff == frac_pkg::OP_DIV) ? rn_ff : rd_ff;
         end
      endcase
   end
   assign prod = ma * mb;

   always_comb begin
      case (op_ff)
         frac_pkg::OP_ADD: num_in = p0_ff + p1_ff;
         frac_pkg::OP_SUB: num_in = p0_ff - p1_ff;
         default:          num_in = p0_ff;
      endcase
   end

   assign nabs = num_ff[P-1] ? -num_ff : num_ff;
   assign dabs = den_ff[P-1] ? -den_ff : den_ff;

   assign stat.den_zero = (den_ff == '0);
   assign stat.gcd_done = (a_ff == '0);

   // Binary gcd step.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (!a_ff[0] && !b_ff[0]) begin
         a_in = a_ff >> 1;
         b_in = b_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!a_ff[0]) begin
         a_in = a_ff >> 1;
      end else if (!b_ff[0]) begin
         b_in = b_ff >> 1;
      end else if (a_ff >= b_ff) begin
         a_in = (a_ff - b_ff) >> 1;
      end else begin
         b_in = (b_ff - a_ff) >> 1;
      end
   end

   // Restoring division of both magnitudes by the gcd.
   assign g_ext  = {1'b0, g_ff};
   assign tn     = {rn_rem_ff, qn_ff[M-1]};
   assign td     = {rd_rem_ff, qd_ff[M-1]};
   assign gen    = (tn >= g_ext);
   assign ged    = (td >= g_ext);
   assign tn_sub = gen ? (tn - g_ext) : tn;
   assign td_sub = ged ? (td - g_ext) : td;

   assign qn_ext = frac_pkg::NUM_OUT_W'(qn_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_data.req_type;
         ln_ff <= take_op(req_data.left_num);
         ld_ff <= take_op(req_data.left_den);
         rn_ff <= take_op(req_data.right_num);
         rd_ff <= take_op(req_data.right_den);
      end
      if (cmd.mul_en) begin
         case (cmd.mul_idx)
            2'd0:    p0_ff <= prod;
            2'd1:    p1_ff <= prod;
            default: p2_ff <= prod;
         endcase
      end
      if (cmd.sum_en) begin
         num_ff <= num_in;
         den_ff <= p2_ff;
      end
      if (cmd.gcd_init) begin
         neg_ff    <= num_ff[P-1] != den_ff[P-1];
         zero_ff   <= (den_ff == '0);
         a_ff      <= nabs[M-1:0];
         b_ff      <= dabs[M-1:0];
         k_ff      <= '0;
         qn_ff     <= nabs[M-1:0];
         qd_ff     <= dabs[M-1:0];
         rn_rem_ff <= '0;
         rd_rem_ff <= '0;
      end
      if (cmd.gcd_step) begin
         a_ff <= a_in;
         b_ff <= b_in;
         k_ff <= k_in;
      end
      if (cmd.gcd_fin) begin
         g_ff <= b_ff << k_ff;
      end
      if (cmd.div_step) begin
         rn_rem_ff <= tn_sub[M-1:0];
         rd_rem_ff <= td_sub[M-1:0];
         qn_ff     <= {qn_ff[M-2:0], gen};
         qd_ff     <= {qd_ff[M-2:0], ged};
      end
      if (cmd.out_load) begin
         if (zero_ff) begin
            rsp_data <= '{result_num: '0, result_den: '0, status: 1'b1};
         end else begin
            rsp_data.result_num <= neg_ff ? -qn_ext : qn_ext;
            rsp_data.result_den <= frac_pkg::DEN_OUT_W'(qd_ff);
            rsp_data.status     <= 1'b0;
         end
      end
   end

endmodule

// ----- hw/rtl/fraction_alu_with_reduction.sv -----
// Flow: operand load, three products, sum, gcd setup, the gcd loop (one step per cycle),
//   then the bit-serial division of both magnitudes by the gcd, then the output register.
//   A zero raw denominator skips the gcd loop and the divider.
// Transfers: one at a time; the gcd loop and the bit-serial divider set the rate.
//   A finished result waits in the output register while the next request is taken.
// Reset: synchronous, active high; clears the controller and the result valid flag.
`include "assert_macros.svh"

module fraction_alu_with_reduction (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  frac_pkg::frac_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output frac_pkg::frac_rsp_type rsp_data
);

   // Controller and datapath talk only through these two groups.
   frac_pkg::frac_cmd_type  cmd;
   frac_pkg::frac_stat_type stat;

   // Result field flags used by the checks below.
   logic rsp_fields_zero;
   logic rsp_den_zero;

   // Sequence: load operands, three products on one multiplier, form
   // numerator, take magnitudes, binary gcd, divide both by the gcd, hold result.
   frac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   frac_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   assign rsp_den_zero    = (rsp_data.result_den == '0);
   assign rsp_fields_zero = (rsp_data.result_num == '0) && rsp_den_zero;

   // A flagged result carries zero fields.
   `ASSERT_CLK_RST(a_zero_den_fields, clock, reset, rsp_valid && rsp_data.status |-> rsp_fields_zero)
   // A good result never has a zero denominator.
   `ASSERT_CLK_RST(a_den_nonzero, clock, reset, rsp_valid && !rsp_data.status |-> !rsp_den_zero)
   // After a request transfer the input side holds off.
   `ASSERT_CLK_RST(a_busy_after_take, clock, reset, req_valid && !req_stall |=> req_stall)
   // Out of reset, no result is offered and the input side is ready.
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall)

endmodule
